FILE: design/owsrch_pkg.sv
// Shared types and constants for the 1-Wire search ROM decision core.
`default_nettype none

package owsrch_pkg;

  localparam int ROM_BITS = 64;
  localparam int POS_W    = 7;
  localparam int BIT_W    = 6;

  // Position zero marks "no discrepancy recorded".
  localparam logic [POS_W-1:0] NO_POS    = 7'h00;
  localparam logic [POS_W-1:0] FIRST_POS = 7'd1;
  localparam logic [POS_W-1:0] LAST_POS  = 7'd64;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [ROM_BITS-1:0] rom_bits;
    logic [POS_W-1:0]    pass_pos;
    logic [POS_W-1:0]    last_branch;
    logic [POS_W-1:0]    newest_zero;
    logic                finished;
  } search_state_t;

  typedef struct packed {
    logic direction;
    logic pass_done;
    logic no_device;
  } pair_result_t;

endpackage

`default_nettype wire

FILE: design/onewire_rom_search_engine_top.sv
// Top level of the 1-Wire search ROM decision core: input stage, state, ROM table, result stage.
//
// Usage: every input beat is one of three kinds. A start beat clears the ROM under
// construction, the discrepancy tracking and the found count, so the ROM table reads as empty.
// A pair beat carries the id bit and complement bit read from the bus; its result beat gives
// the direction bit to write back, and at the 64th bit of a pass the finished ROM, which is
// also stored in the next free table entry. A 1/1 pair flags no_device and ends the
// search. A read beat returns the stored ROM at device_index (zero if never found).
// Every input beat yields exactly one result beat.
// Timing: a beat is registered in the input stage on acceptance, decided combinationally
// there and moves into the output register once that register is free. One beat per cycle
// is sustained while out_ready stays high; the single decision stage between input and
// output registers sets this.
// The table read uses the registered device_index and lands directly in the output stage.
// When out_ready is low the output register holds, the input stage fills, and in_ready
// drops only once both are occupied. Reset returns to the post-start state with both
// stages empty; the table needs no clearing pass since entries beyond the found count
// read as zero.
`default_nettype none

module onewire_rom_search_engine_top
  import owsrch_pkg::*;
#(
  parameter int TABLE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic        id_bit,
  input  wire logic        complement_bit,
  input  wire logic [2:0]  device_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             direction,
  output logic             pass_done,
  output logic [63:0]      rom_value,
  output logic [3:0]       device_count,
  output logic             search_done,
  output logic             no_device
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Input stage
  logic       s1_valid;
  kind_t      s1_kind;
  logic       s1_id;
  logic       s1_cmp;
  logic [2:0] s1_index;
  logic       s1_adv;
  logic       out_free;

  // Search state
  search_state_t st;
  search_state_t st_pair;
  search_state_t st_upd;
  pair_result_t  pair_res;
  logic [CW-1:0] found_count;
  logic [CW-1:0] found_count_next;
  logic          finished_next;
  logic          do_pair;
  logic          do_store;
  logic          do_read;

  logic [ROM_BITS-1:0] rom_table [TABLE_DEPTH];

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind  <= kind_t'(kind);
      s1_id    <= id_bit;
      s1_cmp   <= complement_bit;
      s1_index <= device_index;
    end
  end

  owsrch_decide u_decide (
    .st             (st),
    .id_bit         (s1_id),
    .complement_bit (s1_cmp),
    .st_next        (st_pair),
    .res            (pair_res)
  );

  always_comb begin
    do_pair  = s1_adv && (s1_kind == KIND_PAIR) && !st.finished;
    do_store = do_pair && pair_res.pass_done && (int'(found_count) < TABLE_DEPTH);
    do_read  = s1_adv && (s1_kind == KIND_READ) && (int'(s1_index) < int'(found_count));
    found_count_next = do_store ? found_count + CW'(1) : found_count;
    finished_next    = st_pair.finished;
    if (do_pair && pair_res.pass_done && (int'(found_count_next) >= TABLE_DEPTH)) begin
      finished_next = 1'b1;
    end
    st_upd          = st_pair;
    st_upd.finished = finished_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_adv && s1_kind == KIND_START)) begin
      st.rom_bits    <= '0;
      st.pass_pos    <= FIRST_POS;
      st.last_branch <= NO_POS;
      st.newest_zero <= NO_POS;
      st.finished    <= 1'b0;
      found_count    <= '0;
    end else if (do_pair) begin
      st          <= st_upd;
      found_count <= found_count_next;
    end
  end

  // Entries at or above the found count are never returned, so the table needs no clear.
  always_ff @(posedge clk) begin
    if (do_store) begin
      rom_table[AW'(found_count)] <= st_pair.rom_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      direction    <= 1'b0;
      pass_done    <= 1'b0;
      no_device    <= 1'b0;
      rom_value    <= '0;
      device_count <= 4'(found_count);
      search_done  <= st.finished;
      case (s1_kind)
        KIND_START: begin
          device_count <= '0;
          search_done  <= 1'b0;
        end
        KIND_PAIR: begin
          if (do_pair) begin
            direction    <= pair_res.direction;
            pass_done    <= pair_res.pass_done;
            no_device    <= pair_res.no_device;
            device_count <= 4'(found_count_next);
            search_done  <= finished_next;
            if (pair_res.pass_done) begin
              rom_value <= st_pair.rom_bits;
            end
          end
        end
        KIND_READ: begin
          if (do_read) begin
            rom_value <= rom_table[AW'(s1_index)];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Checks on the search state and result consistency
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(found_count) <= TABLE_DEPTH)
    else $error("found count beyond table depth");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (st.pass_pos >= FIRST_POS) && (st.pass_pos <= LAST_POS))
    else $error("bit position out of range");

  a_nodev_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_device |-> search_done && !pass_done && !direction)
    else $error("no-device beat without end of search");

  a_full_ends: assert property (@(posedge clk) disable iff (rst)
    (int'(found_count) == TABLE_DEPTH) |-> st.finished)
    else $error("full table but search still open");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    st.finished && !(s1_adv && s1_kind == KIND_START) |=> st.finished)
    else $error("finished cleared without start");

endmodule

`default_nettype wire

FILE: design/owsrch_decide.sv
// Per-bit branch decision of the search: picks the write-back bit and advances the pass.
`default_nettype none

module owsrch_decide
  import owsrch_pkg::*;
(
  input  search_state_t st,
  input  logic          id_bit,
  input  logic          complement_bit,
  output search_state_t st_next,
  output pair_result_t  res
);

  logic             conflict;
  logic             dir;
  logic [BIT_W-1:0] bit_idx;
  logic [POS_W-1:0] nz;

  always_comb begin
    conflict = ~id_bit & ~complement_bit;
    bit_idx  = BIT_W'(st.pass_pos - FIRST_POS);
    if (conflict) begin
      if (st.pass_pos < st.last_branch) begin
        dir = st.rom_bits[bit_idx];
      end else if (st.pass_pos == st.last_branch) begin
        dir = 1'b1;
      end else begin
        dir = 1'b0;
      end
    end else begin
      dir = id_bit;
    end
    // Every zero taken on a conflict becomes the newest open branch.
    nz = (conflict && !dir) ? st.pass_pos : st.newest_zero;
  end

  always_comb begin
    st_next = st;
    res     = '0;
    if (id_bit && complement_bit) begin
      // Nobody answered: abort the pass and end the search.
      st_next.finished    = 1'b1;
      st_next.pass_pos    = FIRST_POS;
      st_next.newest_zero = NO_POS;
      res.no_device       = 1'b1;
    end else begin
      res.direction             = dir;
      st_next.rom_bits[bit_idx] = dir;
      st_next.newest_zero       = nz;
      if (st.pass_pos == LAST_POS) begin
        res.pass_done       = 1'b1;
        st_next.pass_pos    = FIRST_POS;
        st_next.newest_zero = NO_POS;
        if (nz == NO_POS) begin
          st_next.finished = 1'b1;
        end else begin
          st_next.last_branch = nz;
        end
      end else begin
        st_next.pass_pos = st.pass_pos + FIRST_POS;
      end
    end
  end

endmodule

`default_nettype wire
